// ===== design/tmva_pkg.sv =====
// ----------------------------------------------------------------------------
// tmva_pkg: shared widths, types and helpers
// Widths of the mixed Voronoi area datapath, most derived from COORD_BITS.
// ----------------------------------------------------------------------------
package tmva_pkg;

   localparam int COORD_BITS = 16;
   localparam int IW  = 16;              // port width of a coordinate
   localparam int AW  = 36;              // area result width
   localparam int EB  = COORD_BITS + 1;  // edge vector component
   localparam int PW  = 2 * EB;          // product of two components
   localparam int CW  = PW + 1;          // cross product component
   localparam int SW  = 2 * CW + 2;      // squared cross norm
   localparam int TW  = SW / 2;          // twice the area
   localparam int RW  = TW + 2;          // root remainder
   localparam int DW  = PW + 2;          // corner dot product, signed
   localparam int LW  = PW + 2;          // squared edge length
   localparam int NW  = LW + DW;         // cotangent numerator
   localparam int DRW = TW + 1;          // division remainder
   localparam int HW  = (DW - 1) / 2;    // low half of a split operand

   typedef struct packed {
      logic [SW-1:0]         rad;
      logic [RW-1:0]         rem;
      logic [TW-1:0]         root;
      logic [2:0][NW-1:0]    num;
      logic [2:0]            obt;
   } sq_type;

   typedef struct packed {
      logic [TW-1:0]         t;
      logic [2:0][NW-1:0]    num;
      logic [2:0][DRW-1:0]   rem;
      logic [2:0][AW-1:0]    q;
      logic [2:0]            obt;
   } dv_type;

   function automatic logic signed [EB-1:0] coord_ext(input logic [IW-1:0] raw);
      logic [IW+COORD_BITS-1:0] tmp;
      logic [COORD_BITS-1:0]    v;
      tmp = {{COORD_BITS{1'b0}}, raw};
      v   = tmp[COORD_BITS-1:0];
      return {v[COORD_BITS-1], v};
   endfunction

   function automatic logic [AW-1:0] fit_area(input logic [TW:0] v);
      logic [AW+TW:0] tmp;
      tmp = {{AW{1'b0}}, v};
      return tmp[AW-1:0];
   endfunction

endpackage

// ===== design/triangle_mixed_voronoi_area.sv =====
// ----------------------------------------------------------------------------
// triangle_mixed_voronoi_area: lumped mass of one triangle's corners
// Mixed Voronoi area (times eight) of each corner of a 3D triangle.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one triangle (three vertices, signed coordinates) per
//   transaction; rsp_* carries the three corner areas and a degenerate flag.
//   One transaction is taken per cycle while req_ready is high, and results
//   come back in order. The pipeline is five front stages, one square root
//   cell per bit of twice the area (36), one division cell per numerator
//   bit (72) and the output register; the division cell row is the longest.
//   Throughput is one triangle per cycle while the skid buffer is empty.
//   A one-entry skid buffer sits behind the output register: when rsp_ready
//   is low, one more result is parked there, then req_ready drops and the
//   whole cell row holds until the skid drains.
//   Synchronous reset empties every stage; no result is pending after it.
// ----------------------------------------------------------------------------
module triangle_mixed_voronoi_area (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [tmva_pkg::IW-1:0]     req_v0_x,
   input  logic signed [tmva_pkg::IW-1:0]     req_v0_y,
   input  logic signed [tmva_pkg::IW-1:0]     req_v0_z,
   input  logic signed [tmva_pkg::IW-1:0]     req_v1_x,
   input  logic signed [tmva_pkg::IW-1:0]     req_v1_y,
   input  logic signed [tmva_pkg::IW-1:0]     req_v1_z,
   input  logic signed [tmva_pkg::IW-1:0]     req_v2_x,
   input  logic signed [tmva_pkg::IW-1:0]     req_v2_y,
   input  logic signed [tmva_pkg::IW-1:0]     req_v2_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tmva_pkg::AW-1:0]            rsp_corner0_area,
   output logic [tmva_pkg::AW-1:0]            rsp_corner1_area,
   output logic [tmva_pkg::AW-1:0]            rsp_corner2_area,
   output logic                               rsp_degenerate
);

   localparam int TW = tmva_pkg::TW;
   localparam int NW = tmva_pkg::NW;
   localparam int AW = tmva_pkg::AW;

   logic                              en;
   logic [2:0][2:0][tmva_pkg::IW-1:0] pts;
   logic                              sq_valid [TW+1];
   tmva_pkg::sq_type                  sq_data  [TW+1];
   logic                              dv_valid [NW+1];
   tmva_pkg::dv_type                  dv_data  [NW+1];
   tmva_pkg::dv_type                  last;
   logic [2:0][AW-1:0]                area;
   logic                              deg;
   logic                              rsp_valid_ff;
   logic [2:0][AW-1:0]                rsp_area_ff;
   logic                              rsp_deg_ff;
   logic                              skid_full_ff;
   logic [2:0][AW-1:0]                skid_area_ff;
   logic                              skid_deg_ff;

   assign en        = !skid_full_ff;
   assign req_ready = en;

   assign pts[0] = {req_v0_z, req_v0_y, req_v0_x};
   assign pts[1] = {req_v1_z, req_v1_y, req_v1_x};
   assign pts[2] = {req_v2_z, req_v2_y, req_v2_x};

   tmva_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && req_ready),
      .pts       (pts),
      .out_valid (sq_valid[0]),
      .out_data  (sq_data[0])
   );

   for (genvar g = 0; g < TW; g++) begin : g_sqrt
      tmva_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sq_valid[g]),
         .in_data   (sq_data[g]),
         .out_valid (sq_valid[g+1]),
         .out_data  (sq_data[g+1])
      );
   end

   assign dv_valid[0]     = sq_valid[TW];
   assign dv_data[0].t    = sq_data[TW].root;
   assign dv_data[0].num  = sq_data[TW].num;
   assign dv_data[0].rem  = '0;
   assign dv_data[0].q    = '0;
   assign dv_data[0].obt  = sq_data[TW].obt;

   for (genvar g = 0; g < NW; g++) begin : g_div
      tmva_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[g]),
         .in_data   (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   always_comb begin
      last = dv_data[NW];
      deg  = last.t == '0;
      for (int i = 0; i < 3; i++) begin
         if (deg) begin
            area[i] = '0;
         end else if (last.obt[i]) begin
            area[i] = tmva_pkg::fit_area({last.t, 1'b0});
         end else if (|last.obt) begin
            area[i] = tmva_pkg::fit_area({1'b0, last.t});
         end else begin
            area[i] = last.q[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff <= dv_valid[NW];
      end else if (dv_valid[NW]) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (rsp_ready) begin
            rsp_area_ff <= skid_area_ff;
            rsp_deg_ff  <= skid_deg_ff;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_area_ff <= area;
         rsp_deg_ff  <= deg;
      end else begin
         skid_area_ff <= area;
         skid_deg_ff  <= deg;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_corner0_area = rsp_area_ff[0];
   assign rsp_corner1_area = rsp_area_ff[1];
   assign rsp_corner2_area = rsp_area_ff[2];
   assign rsp_degenerate   = rsp_deg_ff;

`ifndef SYNTH
   a_skid_has_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_skid_holds : assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !rsp_ready |=> skid_full_ff)
      else $error("skid dropped a transaction under stall");

   a_deg_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_deg_ff |->
         rsp_area_ff[0] == '0 && rsp_area_ff[1] == '0 && rsp_area_ff[2] == '0)
      else $error("degenerate triangle with nonzero area");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !skid_full_ff)
      else $error("output not empty after reset");
`endif

endmodule

// ===== design/tmva_front.sv =====
// ----------------------------------------------------------------------------
// tmva_front: edge, product and sum stages
// Five registered stages from vertices to squared cross norm, numerators and
// obtuse flags, feeding the square root cell row.
// ----------------------------------------------------------------------------
module tmva_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [2:0][2:0][tmva_pkg::IW-1:0]       pts,
   output logic                                    out_valid,
   output tmva_pkg::sq_type                        out_data
);

   localparam int EB = tmva_pkg::EB;
   localparam int PW = tmva_pkg::PW;
   localparam int CW = tmva_pkg::CW;
   localparam int DW = tmva_pkg::DW;
   localparam int LW = tmva_pkg::LW;
   localparam int NW = tmva_pkg::NW;
   localparam int SW = tmva_pkg::SW;
   localparam int HW = tmva_pkg::HW;

   logic [4:0] vld_ff;

   logic signed [EB-1:0] e_in  [3][3];
   logic signed [EB-1:0] e_ff  [3][3];
   logic signed [PW-1:0] xa_in [3];
   logic signed [PW-1:0] xb_in [3];
   logic signed [PW-1:0] dp_in [3][3];
   logic signed [PW-1:0] lp_in [3][3];
   logic signed [PW-1:0] xa_ff [3];
   logic signed [PW-1:0] xb_ff [3];
   logic signed [PW-1:0] dp_ff [3][3];
   logic signed [PW-1:0] lp_ff [3][3];
   logic signed [CW-1:0] c_w   [3];
   logic [CW-1:0]        cm_in [3];
   logic [CW-1:0]        cm_ff [3];
   logic [DW-1:0]        d_in  [3];
   logic [DW-1:0]        d_ff  [3];
   logic [LW-1:0]        l_in  [3];
   logic [LW-1:0]        l_ff  [3];
   logic [2*CW-1:0]      sq_in [3];
   logic [2*CW-1:0]      sq_ff [3];
   logic [LW+HW-1:0]     pal_in [3];
   logic [LW+HW-1:0]     pbl_in [3];
   logic [LW+DW-2-HW:0]  pah_in [3];
   logic [LW+DW-2-HW:0]  pbh_in [3];
   logic [LW+HW-1:0]     pal_ff [3];
   logic [LW+HW-1:0]     pbl_ff [3];
   logic [LW+DW-2-HW:0]  pah_ff [3];
   logic [LW+DW-2-HW:0]  pbh_ff [3];
   logic [2:0]           obt_in;
   logic [2:0]           obt_ff;
   logic [SW-1:0]        s_in;
   logic [SW-1:0]        s_ff;
   logic [2:0][NW-1:0]   num_in;
   logic [2:0][NW-1:0]   num_ff;
   logic [2:0]           obt2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            e_in[i][k] = tmva_pkg::coord_ext(pts[(i + 1) % 3][k])
                       - tmva_pkg::coord_ext(pts[i][k]);
         end
      end
   end

   always_comb begin
      xa_in[0] = e_ff[0][1] * e_ff[1][2];
      xb_in[0] = e_ff[0][2] * e_ff[1][1];
      xa_in[1] = e_ff[0][2] * e_ff[1][0];
      xb_in[1] = e_ff[0][0] * e_ff[1][2];
      xa_in[2] = e_ff[0][0] * e_ff[1][1];
      xb_in[2] = e_ff[0][1] * e_ff[1][0];
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            dp_in[i][k] = e_ff[i][k] * e_ff[(i + 2) % 3][k];
            lp_in[i][k] = e_ff[i][k] * e_ff[i][k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         c_w[k]   = {xa_ff[k][PW-1], xa_ff[k]} - {xb_ff[k][PW-1], xb_ff[k]};
         cm_in[k] = c_w[k][CW-1] ? (~c_w[k] + 1'b1) : c_w[k];
      end
      for (int i = 0; i < 3; i++) begin
         d_in[i] = -({{2{dp_ff[i][0][PW-1]}}, dp_ff[i][0]}
                   + {{2{dp_ff[i][1][PW-1]}}, dp_ff[i][1]}
                   + {{2{dp_ff[i][2][PW-1]}}, dp_ff[i][2]});
         l_in[i] = {{2{lp_ff[i][0][PW-1]}}, lp_ff[i][0]}
                 + {{2{lp_ff[i][1][PW-1]}}, lp_ff[i][1]}
                 + {{2{lp_ff[i][2][PW-1]}}, lp_ff[i][2]};
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = cm_ff[k] * cm_ff[k];
      end
      for (int i = 0; i < 3; i++) begin
         pal_in[i] = l_ff[i] * d_ff[(i + 2) % 3][HW-1:0];
         pah_in[i] = l_ff[i] * d_ff[(i + 2) % 3][DW-2:HW];
         pbl_in[i] = l_ff[(i + 2) % 3] * d_ff[(i + 1) % 3][HW-1:0];
         pbh_in[i] = l_ff[(i + 2) % 3] * d_ff[(i + 1) % 3][DW-2:HW];
         obt_in[i] = d_ff[i][DW-1];
      end
   end

   always_comb begin
      s_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      for (int i = 0; i < 3; i++) begin
         num_in[i] = {{(DW-HW){1'b0}}, pal_ff[i]}
                   + {1'b0, pah_ff[i], {HW{1'b0}}}
                   + {{(DW-HW){1'b0}}, pbl_ff[i]}
                   + {1'b0, pbh_ff[i], {HW{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff    <= e_in;
         xa_ff   <= xa_in;
         xb_ff   <= xb_in;
         dp_ff   <= dp_in;
         lp_ff   <= lp_in;
         cm_ff   <= cm_in;
         d_ff    <= d_in;
         l_ff    <= l_in;
         sq_ff   <= sq_in;
         pal_ff  <= pal_in;
         pah_ff  <= pah_in;
         pbl_ff  <= pbl_in;
         pbh_ff  <= pbh_in;
         obt_ff  <= obt_in;
         s_ff    <= s_in;
         num_ff  <= num_in;
         obt2_ff <= obt_ff;
      end
   end

   assign out_valid     = vld_ff[4];
   assign out_data.rad  = s_ff;
   assign out_data.rem  = '0;
   assign out_data.root = '0;
   assign out_data.num  = num_ff;
   assign out_data.obt  = obt2_ff;

endmodule

// ===== design/tmva_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tmva_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, decides one root bit, hands the rest on.
// ----------------------------------------------------------------------------
module tmva_sqrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  tmva_pkg::sq_type in_data,
   output logic             out_valid,
   output tmva_pkg::sq_type out_data
);

   localparam int SW = tmva_pkg::SW;
   localparam int RW = tmva_pkg::RW;
   localparam int TW = tmva_pkg::TW;

   logic             valid_ff;
   tmva_pkg::sq_type data_ff;
   tmva_pkg::sq_type data_in;
   logic [RW-1:0]    rx;
   logic [RW-1:0]    trial;
   logic             ge;

   always_comb begin
      rx            = {in_data.rem[RW-3:0], in_data.rad[SW-1:SW-2]};
      trial         = {in_data.root, 2'b01};
      ge            = rx >= trial;
      data_in       = in_data;
      data_in.rad   = {in_data.rad[SW-3:0], 2'b00};
      data_in.rem   = ge ? rx - trial : rx;
      data_in.root  = {in_data.root[TW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/tmva_div_cell.sv =====
// ----------------------------------------------------------------------------
// tmva_div_cell: one restoring division step for all three corners
// Shifts one numerator bit into each remainder and records a quotient bit.
// ----------------------------------------------------------------------------
module tmva_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  tmva_pkg::dv_type in_data,
   output logic             out_valid,
   output tmva_pkg::dv_type out_data
);

   localparam int NW  = tmva_pkg::NW;
   localparam int DRW = tmva_pkg::DRW;
   localparam int AW  = tmva_pkg::AW;

   logic             valid_ff;
   tmva_pkg::dv_type data_ff;
   tmva_pkg::dv_type data_in;
   logic [DRW-1:0]   rx [3];
   logic [DRW-1:0]   dvs;
   logic [2:0]       ge;

   always_comb begin
      dvs     = {1'b0, in_data.t};
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         rx[i]          = {in_data.rem[i][DRW-2:0], in_data.num[i][NW-1]};
         ge[i]          = rx[i] >= dvs;
         data_in.rem[i] = ge[i] ? rx[i] - dvs : rx[i];
         data_in.q[i]   = {in_data.q[i][AW-2:0], ge[i]};
         data_in.num[i] = {in_data.num[i][NW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
